[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/scfr_pkg.sv]
// package: constants, status codes and result type of the serial can frame receiver
package scfr_pkg;

  localparam int MAX_PAYLOAD     = 8;
  localparam int CMD_FRAME_BYTES = 20;
  localparam int NUM_BYTES       = 8;
  localparam int CNT_W           = 5;
  localparam int IDX_W           = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  localparam int ID_LOW_POS    = 2;
  localparam int ID_HIGH_POS   = 3;
  localparam int PAYLOAD_POS   = 4;
  localparam int DATA_OVERHEAD = 5;

  localparam logic [7:0] START_BYTE  = 8'haa;
  localparam logic [7:0] CMD_TYPE    = 8'h55;
  localparam logic [3:0] DATA_NIBBLE = 4'hc;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_DATA   = 2'd0;
  localparam status_t STATUS_CKSUM  = 2'd1;
  localparam status_t STATUS_LENGTH = 2'd2;

  typedef struct packed {
    status_t                         status;
    logic [15:0]                     can_id;
    logic [3:0]                      payload_length;
    logic [NUM_BYTES-1:0][7:0]       payload;
  } result_t;

endpackage

[hw/rtl/scfr_rx_if.sv]
// channel interface carrying serial bytes into the receiver
interface scfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[hw/rtl/scfr_res_if.sv]
// channel interface carrying decoded frame results
interface scfr_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [15:0] can_id;
  logic [3:0] payload_length;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic [7:0] byte5;
  logic [7:0] byte6;
  logic [7:0] byte7;

  modport source (output valid, output status, output can_id, output payload_length,
                  output byte0, output byte1, output byte2, output byte3,
                  output byte4, output byte5, output byte6, output byte7, input ready);
  modport sink   (input valid, input status, input can_id, input payload_length,
                  input byte0, input byte1, input byte2, input byte3,
                  input byte4, input byte5, input byte6, input byte7, output ready);
endinterface

[hw/rtl/scfr_parser.sv]
// input byte register and frame parser state machine
module scfr_parser (
  input  logic             clk,
  input  logic             rst,
  scfr_rx_if.sink          rx,
  input  logic             full,
  output logic             push,
  output scfr_pkg::result_t push_data
);
  import scfr_pkg::*;

  logic             vld_q;
  logic [7:0]       byte_q;
  logic             advance;

  logic [CNT_W-1:0] byte_count;
  logic [7:0]       type_byte;
  logic [7:0]       id_low_byte;
  logic [7:0]       id_high_byte;
  logic [7:0]       sum_accumulator;
  logic [7:0]       payload_store [MAX_PAYLOAD];

  logic [CNT_W-1:0] byte_count_next;
  logic [7:0]       type_byte_next;
  logic [7:0]       sum_accumulator_next;
  logic             id_low_we;
  logic             id_high_we;
  logic             store_we;
  logic [IDX_W-1:0] store_idx;
  logic             emit;
  result_t          res;

  assign rx.ready = !vld_q || !full;
  assign advance  = vld_q && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
    end else if (rx.ready) begin
      vld_q <= rx.valid;
    end
    if (rx.valid && rx.ready) begin
      byte_q <= rx.rx_byte;
    end
  end

  always_comb begin
    logic [CNT_W:0]   cnt_p1;
    logic [CNT_W:0]   data_total;
    logic [3:0]       dlc;
    logic [CNT_W-1:0] pidx;

    cnt_p1     = {1'b0, byte_count} + (CNT_W+1)'(1);
    dlc        = type_byte[3:0];
    data_total = (CNT_W+1)'(dlc) + (CNT_W+1)'(DATA_OVERHEAD);
    pidx       = byte_count - CNT_W'(PAYLOAD_POS);

    byte_count_next      = byte_count;
    type_byte_next       = type_byte;
    sum_accumulator_next = sum_accumulator;
    id_low_we            = 1'b0;
    id_high_we           = 1'b0;
    store_we             = 1'b0;
    store_idx            = pidx[IDX_W-1:0];
    emit                 = 1'b0;
    res                  = '0;

    priority if (byte_count == '0) begin
      if (byte_q == START_BYTE) begin
        byte_count_next = CNT_W'(1);
      end
    end else if (byte_count == CNT_W'(1)) begin
      type_byte_next       = byte_q;
      sum_accumulator_next = '0;
      if (byte_q == CMD_TYPE || byte_q[7:4] == DATA_NIBBLE) begin
        byte_count_next = CNT_W'(2);
      end else begin
        byte_count_next = '0;
      end
    end else if (type_byte == CMD_TYPE) begin
      if (cnt_p1 >= (CNT_W+1)'(CMD_FRAME_BYTES)) begin
        // last byte carries the checksum
        byte_count_next = '0;
        if (byte_q != sum_accumulator) begin
          emit       = 1'b1;
          res.status = STATUS_CKSUM;
        end
      end else begin
        sum_accumulator_next = sum_accumulator + byte_q;
        byte_count_next      = cnt_p1[CNT_W-1:0];
      end
    end else if (type_byte[7:4] != DATA_NIBBLE) begin
      byte_count_next = '0;
    end else if (cnt_p1 >= data_total) begin
      // end byte of a data frame, not checked
      byte_count_next = '0;
      if (dlc != 4'd0) begin
        emit       = 1'b1;
        res.can_id = {id_high_byte, id_low_byte};
        if (dlc > 4'(MAX_PAYLOAD)) begin
          res.status = STATUS_LENGTH;
        end else begin
          res.status         = STATUS_DATA;
          res.payload_length = dlc;
          for (int j = 0; j < NUM_BYTES; j++) begin
            if (j < MAX_PAYLOAD && 4'(j) < dlc) begin
              res.payload[j] = payload_store[IDX_W'(j % MAX_PAYLOAD)];
            end
          end
        end
      end
    end else begin
      byte_count_next = cnt_p1[CNT_W-1:0];
      if (byte_count == CNT_W'(ID_LOW_POS)) begin
        id_low_we = 1'b1;
      end else if (byte_count == CNT_W'(ID_HIGH_POS)) begin
        id_high_we = 1'b1;
      end else if (pidx < CNT_W'(MAX_PAYLOAD)) begin
        store_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      type_byte       <= '0;
      id_low_byte     <= '0;
      id_high_byte    <= '0;
      sum_accumulator <= '0;
    end else if (advance) begin
      byte_count      <= byte_count_next;
      type_byte       <= type_byte_next;
      sum_accumulator <= sum_accumulator_next;
      if (id_low_we) begin
        id_low_byte <= byte_q;
      end
      if (id_high_we) begin
        id_high_byte <= byte_q;
      end
    end
    if (advance && store_we) begin
      payload_store[store_idx] <= byte_q;
    end
  end

  assign push      = advance && emit;
  assign push_data = res;

endmodule

[hw/rtl/scfr_out_buf.sv]
// two-entry result buffer driving the result channel
module scfr_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  scfr_pkg::result_t push_data,
  output logic              full,
  scfr_res_if.source        res
);
  import scfr_pkg::*;

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;
  result_t    head;

  assign pop  = res.valid && res.ready;
  assign full = (count == 2'd2);
  assign head = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  assign res.valid          = (count != 2'd0);
  assign res.status         = head.status;
  assign res.can_id         = head.can_id;
  assign res.payload_length = head.payload_length;
  assign res.byte0          = head.payload[0];
  assign res.byte1          = head.payload[1];
  assign res.byte2          = head.payload[2];
  assign res.byte3          = head.payload[3];
  assign res.byte4          = head.payload[4];
  assign res.byte5          = head.payload[5];
  assign res.byte6          = head.payload[6];
  assign res.byte7          = head.payload[7];

endmodule

[hw/rtl/serial_can_frame_receiver_top.sv]
// top level of the serial can frame receiver
//
//   channel | dir | payload                                   | request
//   rx      | in  | rx_byte                                   | one serial byte
//   res     | out | status, can_id, payload_length, byte0..7 | one decoded frame result
//
// one byte is taken per cycle while rx.ready is high; a byte passes the input register,
// then the parser, and lands in a two-entry result buffer that drives the res channel
// rx.ready drops only while the input register is held and the result buffer is full
// synchronous reset clears the frame state and empties the buffer; payload storage is not cleared
module serial_can_frame_receiver_top (
  input  logic       clk,
  input  logic       rst,
  scfr_rx_if.sink    rx,
  scfr_res_if.source res
);
  import scfr_pkg::*;

  logic    full;
  logic    push;
  result_t push_data;

  scfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  scfr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .res       (res)
  );

endmodule

[hw/rtl/scfr_checker.sv]
// port-level checker for the serial can frame receiver and its bind
`include "assert_macros.svh"

module scfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  status,
  input logic [15:0] can_id,
  input logic [3:0]  payload_length
);
  import scfr_pkg::*;

  logic status_known;
  logic cksum_clean;
  logic data_len_ok;

  assign status_known = (status == STATUS_DATA) || (status == STATUS_CKSUM) ||
                        (status == STATUS_LENGTH);
  assign cksum_clean  = (can_id == 16'd0) && (payload_length == 4'd0);
  assign data_len_ok  = (payload_length != 4'd0) && (payload_length <= 4'(MAX_PAYLOAD));

  `ASSERT_ALWAYS(a_idle_after_reset, rst |=> !res_valid, "result valid right after reset")
  `ASSERT_CLK(a_status_code, res_valid |-> status_known, "unknown status code")
  `ASSERT_CLK(a_cksum_fields, (res_valid && status == STATUS_CKSUM) |-> cksum_clean, "checksum error carries fields")
  `ASSERT_CLK(a_data_length, (res_valid && status == STATUS_DATA) |-> data_len_ok, "data length out of range")
  `ASSERT_CLK(a_res_hold, (res_valid && !res_ready) |=> (res_valid && $stable(can_id) && $stable(status)), "stalled result changed")

endmodule

bind serial_can_frame_receiver_top scfr_checker u_scfr_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .status         (res.status),
  .can_id         (res.can_id),
  .payload_length (res.payload_length)
);
